// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the text tokenizer.
// Include this file by name only; it depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/stt_pkg.sv
// Types and constants of the SQL text tokenizer.
// Used by sql_text_tokenizer, stt_token_checker and tb_top; depends on nothing else.
package stt_pkg;

	localparam int OUT_BITS = 16;

	localparam logic [2:0] MODE_SEEK    = 3'd0;
	localparam logic [2:0] MODE_DASH    = 3'd1;
	localparam logic [2:0] MODE_COMMENT = 3'd2;
	localparam logic [2:0] MODE_BARE    = 3'd3;
	localparam logic [2:0] MODE_QUOTED  = 3'd4;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_DASH      = 8'h2D;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last;
	} src_beat_t;

	typedef struct packed {
		logic                token_valid;
		logic [OUT_BITS-1:0] token_start;
		logic [OUT_BITS-1:0] token_length;
		logic                quoted;
		logic                text_done;
	} res_beat_t;

endpackage

// File: rtl/sql_text_tokenizer.sv
// Top level of the SQL text tokenizer: byte stream in, token reports out.
// Depends on stt_pkg and assert_macros.svh.
//
// Usage:
// The src channel carries one text byte per beat with a last flag; a zero
// byte also ends the text and is not counted. The res channel carries one
// beat per token and one text_done beat that closes each text; a token
// that ends the text rides in that beat. Both channels use valid/ready.
// A byte is registered on acceptance, classified against the scan state in
// the next cycle, and any result is written into a four-entry output
// queue, whose head drives the res channel.
// One byte is accepted per cycle as long as the queue and the input stage
// together hold fewer than four entries; this credit check uses registers
// only, so bytes keep flowing while results wait to be taken.
// When the receiver stalls, results queue up, and src_ready drops while the
// queued results plus the byte in the input stage reach four.
// Reset clears the scan state, the input stage and the queue; the first
// byte after reset or after a closed text starts a new text at offset 0.
`include "assert_macros.svh"

module sql_text_tokenizer #(
	parameter int OFFSET_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  stt_pkg::src_beat_t src_beat,
	output logic               res_valid,
	input  logic               res_ready,
	output stt_pkg::res_beat_t res_beat
);

	localparam int XW = (OFFSET_BITS > stt_pkg::OUT_BITS) ? OFFSET_BITS : stt_pkg::OUT_BITS;
	localparam logic [XW-1:0] OUT_LIMIT = XW'({stt_pkg::OUT_BITS{1'b1}});
	localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};

	logic                   valid_s1;
	stt_pkg::src_beat_t     beat_s1;

	logic [2:0]             mode_q;
	logic                   comment_q;
	logic                   dquote_q;
	logic                   bslash_q;
	logic [OFFSET_BITS-1:0] boff_q;
	logic [OFFSET_BITS-1:0] start_q;

	stt_pkg::res_beat_t     fifo_q [4];
	logic [1:0]             wr_q;
	logic [1:0]             rd_q;
	logic [2:0]             cnt_q;

	logic [2:0]             mode_n;
	logic                   comment_n;
	logic                   dquote_n;
	logic                   bslash_n;
	logic [OFFSET_BITS-1:0] boff_n;
	logic [OFFSET_BITS-1:0] start_n;
	logic                   hit;
	logic                   hit_q_end;
	logic                   emit;
	logic                   r_valid;
	logic [OFFSET_BITS-1:0] r_start;
	logic [OFFSET_BITS-1:0] r_end;
	logic                   r_quoted;
	logic                   r_done;
	logic [OFFSET_BITS-1:0] r_len;
	logic [XW-1:0]          start_x;
	logic [XW-1:0]          len_x;
	logic [OFFSET_BITS-1:0] inc_off;
	logic [7:0]             b;
	logic                   is_ws;
	logic                   is_sep;
	logic                   push;
	logic                   pop;
	logic                   clear_state;
	stt_pkg::res_beat_t     res_new;

	assign src_ready = ({1'b0, cnt_q} + {3'b000, valid_s1}) < 4'd4;
	assign res_valid = (cnt_q != 3'd0);
	assign res_beat  = fifo_q[rd_q];
	assign pop       = res_valid && res_ready;

	assign b       = beat_s1.text_byte;
	assign is_ws   = (b == stt_pkg::CH_SPACE) ||
		((b >= stt_pkg::CH_TAB) && (b <= stt_pkg::CH_CR));
	assign is_sep  = (b == stt_pkg::CH_SEMICOLON) || (b == stt_pkg::CH_COMMA);
	assign inc_off = (boff_q == OFS_MAX) ? boff_q : boff_q + OFFSET_BITS'(1);

	// Per-byte scan step.
	always_comb begin
		mode_n    = mode_q;
		comment_n = comment_q;
		dquote_n  = dquote_q;
		bslash_n  = bslash_q;
		start_n   = start_q;
		hit       = 1'b0;
		hit_q_end = 1'b0;
		case (mode_q)
			stt_pkg::MODE_SEEK: begin
				if (!is_ws) begin
					start_n = boff_q;
					if (!comment_q && b == stt_pkg::CH_DASH) begin
						mode_n = stt_pkg::MODE_DASH;
					end else if (b == stt_pkg::CH_SQUOTE || b == stt_pkg::CH_DQUOTE) begin
						mode_n   = stt_pkg::MODE_QUOTED;
						dquote_n = (b == stt_pkg::CH_DQUOTE);
						bslash_n = 1'b0;
					end else begin
						mode_n = stt_pkg::MODE_BARE;
					end
				end
			end
			stt_pkg::MODE_DASH, stt_pkg::MODE_BARE: begin
				if (mode_q == stt_pkg::MODE_DASH && b == stt_pkg::CH_DASH) begin
					mode_n = stt_pkg::MODE_COMMENT;
				end else if (is_ws) begin
					hit       = 1'b1;
					mode_n    = stt_pkg::MODE_SEEK;
					comment_n = 1'b0;
				end else if (is_sep) begin
					hit       = 1'b1;
					mode_n    = stt_pkg::MODE_BARE;
					start_n   = boff_q;
					comment_n = 1'b0;
				end else begin
					mode_n = stt_pkg::MODE_BARE;
				end
			end
			stt_pkg::MODE_COMMENT: begin
				if (b == stt_pkg::CH_NEWLINE) begin
					mode_n    = stt_pkg::MODE_SEEK;
					comment_n = 1'b1;
				end
			end
			stt_pkg::MODE_QUOTED: begin
				if (b == (dquote_q ? stt_pkg::CH_DQUOTE : stt_pkg::CH_SQUOTE) && !bslash_q) begin
					hit       = 1'b1;
					hit_q_end = 1'b1;
					mode_n    = stt_pkg::MODE_SEEK;
					comment_n = 1'b0;
				end else begin
					bslash_n = (b == stt_pkg::CH_BACKSLASH);
				end
			end
			default: begin
				mode_n = stt_pkg::MODE_SEEK;
			end
		endcase
		boff_n = inc_off;
	end

	// Result selection for the byte in the input stage.
	always_comb begin
		r_start     = start_q;
		r_end       = hit_q_end ? inc_off : boff_q;
		r_quoted    = hit_q_end;
		r_valid     = hit;
		r_done      = 1'b0;
		emit        = hit;
		clear_state = 1'b0;
		if (b == stt_pkg::CH_NUL) begin
			r_valid     = (mode_q == stt_pkg::MODE_DASH) || (mode_q == stt_pkg::MODE_BARE) ||
				(mode_q == stt_pkg::MODE_QUOTED);
			r_start     = start_q;
			r_end       = boff_q;
			r_quoted    = (mode_q == stt_pkg::MODE_QUOTED);
			r_done      = 1'b1;
			emit        = 1'b1;
			clear_state = 1'b1;
		end else if (beat_s1.last) begin
			r_done      = 1'b1;
			emit        = 1'b1;
			clear_state = 1'b1;
			if (!hit) begin
				r_valid  = (mode_n == stt_pkg::MODE_DASH) || (mode_n == stt_pkg::MODE_BARE) ||
					(mode_n == stt_pkg::MODE_QUOTED);
				r_start  = start_n;
				r_end    = boff_n;
				r_quoted = (mode_n == stt_pkg::MODE_QUOTED);
			end
		end
		r_len   = (r_end >= r_start) ? r_end - r_start : '0;
		start_x = XW'(r_start);
		len_x   = XW'(r_len);
		res_new.token_valid  = r_valid;
		res_new.token_start  = !r_valid ? '0 :
			(start_x > OUT_LIMIT) ? OUT_LIMIT[stt_pkg::OUT_BITS-1:0] :
			start_x[stt_pkg::OUT_BITS-1:0];
		res_new.token_length = !r_valid ? '0 :
			(len_x > OUT_LIMIT) ? OUT_LIMIT[stt_pkg::OUT_BITS-1:0] :
			len_x[stt_pkg::OUT_BITS-1:0];
		res_new.quoted       = r_valid && r_quoted;
		res_new.text_done    = r_done;
	end

	assign push = valid_s1 && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= src_valid && src_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			beat_s1 <= src_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= stt_pkg::MODE_SEEK;
			comment_q <= 1'b0;
			dquote_q  <= 1'b0;
			bslash_q  <= 1'b0;
			boff_q    <= '0;
			start_q   <= '0;
		end else if (valid_s1) begin
			if (clear_state) begin
				mode_q    <= stt_pkg::MODE_SEEK;
				comment_q <= 1'b0;
				dquote_q  <= 1'b0;
				bslash_q  <= 1'b0;
				boff_q    <= '0;
				start_q   <= '0;
			end else begin
				mode_q    <= mode_n;
				comment_q <= comment_n;
				dquote_q  <= dquote_n;
				bslash_q  <= bslash_n;
				boff_q    <= boff_n;
				start_q   <= start_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 3'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= res_new;
		end
	end

	`ASSERT_SAME(a_credit_ok, clk, arst_n, src_ready, ({1'b0, cnt_q} + {3'b000, valid_s1}) < 4'd4)
	`ASSERT_NEXT(a_close_resets, clk, arst_n, push && res_new.text_done, boff_q == '0 && mode_q == stt_pkg::MODE_SEEK)
	`ASSERT_NEXT(a_queue_hold, clk, arst_n, !push && !pop, $stable(cnt_q) && $stable(wr_q))
	`ASSERT_SAME(a_no_overflow, clk, arst_n, push && !pop, cnt_q < 3'd4)

endmodule

// File: tb/stt_token_checker.sv
// Token checker for the SQL text tokenizer: predicts every result beat from the bytes
// accepted on the src channel and compares them with the res channel.
// Depends on stt_pkg.
`timescale 1ns / 100ps

module stt_token_checker #(
	parameter int OFFSET_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	input  logic               src_ready,
	input  stt_pkg::src_beat_t src_beat,
	input  logic               res_valid,
	input  logic               res_ready,
	input  stt_pkg::res_beat_t res_beat,
	output int                 n_errors,
	output int                 n_pending
);

	localparam int OUT_W = stt_pkg::OUT_BITS;
	localparam bit [OFFSET_BITS-1:0] OFS_MAX = '1;
	localparam longint unsigned OUT_MAX = (64'd1 << OUT_W) - 1;

	bit [2:0]             scan_mode;
	bit                   comment_taken;
	bit                   dq_open;
	bit                   prior_bs;
	bit [OFFSET_BITS-1:0] next_ofs;
	bit [OFFSET_BITS-1:0] tok_ofs;

	bit                   hit;
	bit                   hit_quoted;
	bit [OFFSET_BITS-1:0] hit_start;
	bit [OFFSET_BITS-1:0] hit_end;

	stt_pkg::res_beat_t expected_tokens[$];

	function automatic void clear_scan();
		scan_mode = stt_pkg::MODE_SEEK;
		comment_taken = 1'b0;
		dq_open = 1'b0;
		prior_bs = 1'b0;
		next_ofs = '0;
		tok_ofs = '0;
	endfunction

	function automatic bit is_blank(input logic [7:0] b);
		return b == stt_pkg::CH_SPACE || (b >= stt_pkg::CH_TAB && b <= stt_pkg::CH_CR);
	endfunction

	function automatic bit [OFFSET_BITS-1:0] sat_inc(input bit [OFFSET_BITS-1:0] v);
		return (v == OFS_MAX) ? v : v + OFFSET_BITS'(1);
	endfunction

	function automatic bit is_open_mode();
		return scan_mode == stt_pkg::MODE_DASH || scan_mode == stt_pkg::MODE_BARE ||
			scan_mode == stt_pkg::MODE_QUOTED;
	endfunction

	function automatic void note_token(input bit [OFFSET_BITS-1:0] s,
			input bit [OFFSET_BITS-1:0] e, input bit q);
		hit = 1'b1;
		hit_start = s;
		hit_end = e;
		hit_quoted = q;
	endfunction

	function automatic stt_pkg::res_beat_t token_report(input bit valid,
			input bit [OFFSET_BITS-1:0] s, input bit [OFFSET_BITS-1:0] e, input bit q,
			input bit done);
		stt_pkg::res_beat_t r;
		longint unsigned ls;
		longint unsigned ln;
		ls = 64'(s);
		ln = (e >= s) ? 64'(e - s) : 64'd0;
		r = '0;
		r.text_done = done;
		if (valid) begin
			r.token_valid = 1'b1;
			r.token_start = OUT_W'((ls > OUT_MAX) ? OUT_MAX : ls);
			r.token_length = OUT_W'((ln > OUT_MAX) ? OUT_MAX : ln);
			r.quoted = q;
		end
		return r;
	endfunction

	// A separator closes the bare token and opens a new one at its own offset.
	function automatic void bare_char(input logic [7:0] b, input bit [OFFSET_BITS-1:0] off);
		if (is_blank(b)) begin
			note_token(tok_ofs, off, 1'b0);
			scan_mode = stt_pkg::MODE_SEEK;
			comment_taken = 1'b0;
		end else if (b == stt_pkg::CH_SEMICOLON || b == stt_pkg::CH_COMMA) begin
			note_token(tok_ofs, off, 1'b0);
			scan_mode = stt_pkg::MODE_BARE;
			tok_ofs = off;
			comment_taken = 1'b0;
		end else begin
			scan_mode = stt_pkg::MODE_BARE;
		end
	endfunction

	function automatic bit scan_byte(input logic [7:0] b, input logic fin,
			output stt_pkg::res_beat_t r);
		bit [OFFSET_BITS-1:0] off;
		logic [7:0] closer;
		off = next_ofs;
		if (b == stt_pkg::CH_NUL) begin
			r = token_report(is_open_mode(), tok_ofs, off,
				scan_mode == stt_pkg::MODE_QUOTED, 1'b1);
			clear_scan();
			return 1'b1;
		end
		hit = 1'b0;
		case (scan_mode)
			stt_pkg::MODE_SEEK: begin
				if (!is_blank(b)) begin
					tok_ofs = off;
					if (!comment_taken && b == stt_pkg::CH_DASH) begin
						scan_mode = stt_pkg::MODE_DASH;
					end else if (b == stt_pkg::CH_SQUOTE || b == stt_pkg::CH_DQUOTE) begin
						scan_mode = stt_pkg::MODE_QUOTED;
						dq_open = b == stt_pkg::CH_DQUOTE;
						prior_bs = 1'b0;
					end else begin
						scan_mode = stt_pkg::MODE_BARE;
					end
				end
			end
			stt_pkg::MODE_DASH: begin
				if (b == stt_pkg::CH_DASH)
					scan_mode = stt_pkg::MODE_COMMENT;
				else
					bare_char(b, off);
			end
			stt_pkg::MODE_COMMENT: begin
				if (b == stt_pkg::CH_NEWLINE) begin
					scan_mode = stt_pkg::MODE_SEEK;
					comment_taken = 1'b1;
				end
			end
			stt_pkg::MODE_BARE: begin
				bare_char(b, off);
			end
			stt_pkg::MODE_QUOTED: begin
				closer = dq_open ? stt_pkg::CH_DQUOTE : stt_pkg::CH_SQUOTE;
				if (b == closer && !prior_bs) begin
					note_token(tok_ofs, sat_inc(off), 1'b1);
					scan_mode = stt_pkg::MODE_SEEK;
					comment_taken = 1'b0;
				end else begin
					prior_bs = b == stt_pkg::CH_BACKSLASH;
				end
			end
			default: begin
				scan_mode = stt_pkg::MODE_SEEK;
			end
		endcase
		next_ofs = sat_inc(off);
		if (fin) begin
			if (hit)
				r = token_report(1'b1, hit_start, hit_end, hit_quoted, 1'b1);
			else
				r = token_report(is_open_mode(), tok_ofs, next_ofs,
					scan_mode == stt_pkg::MODE_QUOTED, 1'b1);
			clear_scan();
			return 1'b1;
		end
		r = token_report(1'b1, hit_start, hit_end, hit_quoted, 1'b0);
		return hit;
	endfunction

	function automatic void check_field(input string field, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stt_pkg::res_beat_t want;
		stt_pkg::res_beat_t pred;
		if (!arst_n) begin
			clear_scan();
			expected_tokens.delete();
			n_errors = 0;
			n_pending = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_tokens.size() == 0) begin
					$error("result beat with no token expected: %p", res_beat);
					n_errors++;
				end else begin
					want = expected_tokens.pop_front();
					check_field("token_valid", 64'(want.token_valid),
						64'(res_beat.token_valid));
					check_field("token_start", 64'(want.token_start),
						64'(res_beat.token_start));
					check_field("token_length", 64'(want.token_length),
						64'(res_beat.token_length));
					check_field("quoted", 64'(want.quoted), 64'(res_beat.quoted));
					check_field("text_done", 64'(want.text_done),
						64'(res_beat.text_done));
				end
			end
			if (src_valid && src_ready) begin
				if (scan_byte(src_beat.text_byte, src_beat.last, pred))
					expected_tokens.push_back(pred);
			end
			n_pending = expected_tokens.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the SQL text tokenizer testbench: clock, reset, byte stimulus and the verdict.
// Depends on stt_pkg, sql_text_tokenizer and stt_token_checker.
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 20;
	localparam int PHASE_BYTES = 125;
	localparam logic [7:0] CH_VTAB = 8'h0B;
	localparam logic [7:0] CH_FFEED = 8'h0C;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               src_valid = 1'b0;
	logic               src_ready;
	stt_pkg::src_beat_t src_beat = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	stt_pkg::res_beat_t res_beat;

	int        chk_errors;
	int        chk_pending;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        bytes_sent = 0;
	int        cycle_count = 0;
	logic [7:0] text_q[$];

	sql_text_tokenizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_beat (src_beat),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_beat (res_beat)
	);

	stt_token_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_beat (src_beat),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_beat (res_beat),
		.n_errors (chk_errors),
		.n_pending(chk_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	always @(negedge clk) begin
		res_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_top: FAIL");
		$finish;
	end

	task automatic put_byte(input logic [7:0] b, input logic fin);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_beat.text_byte <= b;
		src_beat.last <= fin;
		do begin
			@(posedge clk);
			taken = src_ready;
			@(negedge clk);
		end while (!taken);
		bytes_sent++;
	endtask

	task automatic send_text(input bit zero_end);
		bit z;
		z = zero_end || text_q.size() == 0;
		for (int i = 0; i < text_q.size(); i++)
			put_byte(text_q[i], !z && i == text_q.size() - 1);
		if (z)
			put_byte(stt_pkg::CH_NUL, 1'($urandom_range(1)));
	endtask

	function automatic void push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	task automatic send_str(input string s, input bit zero_end);
		text_q.delete();
		push_str(s);
		send_text(zero_end);
	endtask

	function automatic logic [7:0] blank_char();
		case ($urandom_range(5))
			0: return stt_pkg::CH_SPACE;
			1: return stt_pkg::CH_TAB;
			2: return stt_pkg::CH_NEWLINE;
			3: return CH_VTAB;
			4: return CH_FFEED;
			default: return stt_pkg::CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] word_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(255, 1));
		end while (c == stt_pkg::CH_SPACE || (c >= stt_pkg::CH_TAB && c <= stt_pkg::CH_CR)
			|| c == stt_pkg::CH_SEMICOLON || c == stt_pkg::CH_COMMA
			|| c == stt_pkg::CH_SQUOTE || c == stt_pkg::CH_DQUOTE);
		return c;
	endfunction

	// Mostly well-formed texts built from words, separators, comments and quoted
	// strings; one text in ten is arbitrary nonzero bytes.
	function automatic void build_random_text();
		logic [7:0] q;
		text_q.delete();
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(12, 1))
				text_q.push_back(8'($urandom_range(255, 1)));
			return;
		end
		repeat ($urandom_range(8, 1)) begin
			case ($urandom_range(5))
				0: begin
					repeat ($urandom_range(3, 1))
						text_q.push_back(blank_char());
				end
				1: begin
					text_q.push_back(stt_pkg::CH_DASH);
					text_q.push_back(stt_pkg::CH_DASH);
					repeat ($urandom_range(5))
						text_q.push_back(word_char());
					text_q.push_back(stt_pkg::CH_NEWLINE);
				end
				2, 3: begin
					if ($urandom_range(2) == 0)
						text_q.push_back(stt_pkg::CH_DASH);
					repeat ($urandom_range(6, 1))
						text_q.push_back(word_char());
				end
				4: begin
					text_q.push_back($urandom_range(1) ? stt_pkg::CH_SEMICOLON :
						stt_pkg::CH_COMMA);
				end
				default: begin
					q = $urandom_range(1) ? stt_pkg::CH_DQUOTE : stt_pkg::CH_SQUOTE;
					text_q.push_back(q);
					repeat ($urandom_range(6)) begin
						case ($urandom_range(5))
							0: text_q.push_back(stt_pkg::CH_BACKSLASH);
							1: text_q.push_back($urandom_range(1) ? stt_pkg::CH_DQUOTE :
								stt_pkg::CH_SQUOTE);
							default: text_q.push_back(8'($urandom_range(255, 1)));
						endcase
					end
					if ($urandom_range(4) != 0)
						text_q.push_back(q);
				end
			endcase
			if ($urandom_range(9) < 6)
				text_q.push_back(blank_char());
		end
	endfunction

	initial begin
		int phase_start;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_str(" a;b,", 1'b0);
		send_str("\t--c\n -x", 1'b1);
		send_str("--x\n--y\n", 1'b0);
		send_str("'a\\'b'", 1'b0);
		send_str("\"x", 1'b1);
		send_str("-", 1'b0);
		send_str("-,y ", 1'b1);
		text_q.delete();
		text_q.push_back(CH_VTAB);
		text_q.push_back(8'hFF);
		text_q.push_back(8'h80);
		text_q.push_back(CH_FFEED);
		text_q.push_back(stt_pkg::CH_CR);
		send_text(1'b0);
		text_q.delete();
		send_text(1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 81; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 81; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				build_random_text();
				send_text($urandom_range(9) < 3);
			end
		end

		src_valid <= 1'b0;
		while (chk_pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (chk_errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/stt_pkg.sv
rtl/sql_text_tokenizer.sv
tb/stt_token_checker.sv
tb/tb_top.sv
